/* design/pf2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// pf2rgb_pkg
// shared types and constants of the pixel format to rgb24 unit
// ----------------------------------------------------------------------------
package pf2rgb_pkg;

	typedef enum logic [2:0] {
		MODE_RGB565 = 3'd0,
		MODE_BGR24  = 3'd1,
		MODE_RGB24  = 3'd2,
		MODE_BGR32  = 3'd3,
		MODE_RGB32  = 3'd4,
		MODE_YUY2   = 3'd5,
		MODE_UYVY   = 3'd6,
		MODE_PLANAR = 3'd7
	} src_mode_t;

	// one pixel beat handed from the unpacker to the color pipeline
	typedef struct packed {
		logic       yuv;
		logic       video;
		logic       last;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] luma;
		logic [7:0] cb;
		logic [7:0] cr;
	} pix_job_t;

	// coefficients in millionths
	localparam longint unsigned MICRO         = 64'd1000000;
	localparam longint unsigned FR_R_V_MICRO  = 64'd1370705;
	localparam longint unsigned FR_G_V_MICRO  = 64'd698001;
	localparam longint unsigned FR_G_U_MICRO  = 64'd337633;
	localparam longint unsigned FR_B_U_MICRO  = 64'd1732446;
	localparam longint unsigned VR_Y_MICRO    = 64'd1164000;
	localparam longint unsigned VR_R_V_MICRO  = 64'd1596000;
	localparam longint unsigned VR_G_V_MICRO  = 64'd813000;
	localparam longint unsigned VR_G_U_MICRO  = 64'd391000;
	localparam longint unsigned VR_B_U_MICRO  = 64'd2018000;

	localparam logic [8:0] LUMA_OFFSET   = 9'd16;
	localparam logic [8:0] CHROMA_OFFSET = 9'd128;

endpackage

/* design/pixel_format_to_rgb24_unit.sv */
// ----------------------------------------------------------------------------
// pixel_format_to_rgb24_unit
// converts packed rgb and luma-chroma source units into 24-bit bmp pixels
// ----------------------------------------------------------------------------
// One pixel leaves per cycle while the receiver takes them. An rgb565, bgr24,
// rgb24, bgr32 or rgb32 unit gives one pixel; a yuy2, uyvy or planar unit is
// held for two pixel beats and gives two pixels sharing one chroma pair, the second flagged by
// last_pixel. The unit register and four pipeline stages (operand prep,
// coefficient multiply, sum, shift and clamp) lie between the input beat
// and its first pixel. The user must write source_mode over the cfg channel
// only while no unit is in flight; the block itself does not enforce this.
// It is sampled when a unit is taken.
// ----------------------------------------------------------------------------
module pixel_format_to_rgb24_unit #(
	parameter int COEF_FRAC_BITS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_zero,
	input  logic [7:0] byte_one,
	input  logic [7:0] byte_two,
	input  logic [7:0] byte_three,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] blue_out,
	output logic [7:0] green_out,
	output logic [7:0] red_out,
	output logic       last_pixel
);

	localparam int ACC_W = COEF_FRAC_BITS + 11;

	localparam logic signed [ACC_W-1:0] K_FR_RV = ACC_W'((pf2rgb_pkg::FR_R_V_MICRO
		<< COEF_FRAC_BITS) / pf2rgb_pkg::MICRO);
	localparam logic signed [ACC_W-1:0] K_FR_GV = ACC_W'((pf2rgb_pkg::FR_G_V_MICRO
		<< COEF_FRAC_BITS) / pf2rgb_pkg::MICRO);
	localparam logic signed [ACC_W-1:0] K_FR_GU = ACC_W'((pf2rgb_pkg::FR_G_U_MICRO
		<< COEF_FRAC_BITS) / pf2rgb_pkg::MICRO);
	localparam logic signed [ACC_W-1:0] K_FR_BU = ACC_W'((pf2rgb_pkg::FR_B_U_MICRO
		<< COEF_FRAC_BITS) / pf2rgb_pkg::MICRO);
	localparam logic signed [ACC_W-1:0] K_VR_Y  = ACC_W'((pf2rgb_pkg::VR_Y_MICRO
		<< COEF_FRAC_BITS) / pf2rgb_pkg::MICRO);
	localparam logic signed [ACC_W-1:0] K_VR_RV = ACC_W'((pf2rgb_pkg::VR_R_V_MICRO
		<< COEF_FRAC_BITS) / pf2rgb_pkg::MICRO);
	localparam logic signed [ACC_W-1:0] K_VR_GV = ACC_W'((pf2rgb_pkg::VR_G_V_MICRO
		<< COEF_FRAC_BITS) / pf2rgb_pkg::MICRO);
	localparam logic signed [ACC_W-1:0] K_VR_GU = ACC_W'((pf2rgb_pkg::VR_G_U_MICRO
		<< COEF_FRAC_BITS) / pf2rgb_pkg::MICRO);
	localparam logic signed [ACC_W-1:0] K_VR_BU = ACC_W'((pf2rgb_pkg::VR_B_U_MICRO
		<< COEF_FRAC_BITS) / pf2rgb_pkg::MICRO);

	function automatic logic [7:0] shift_clamp(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] s;
		s = x >>> COEF_FRAC_BITS;
		if (s < 0)
			shift_clamp = 8'd0;
		else if (s > ACC_W'(255))
			shift_clamp = 8'd255;
		else
			shift_clamp = s[7:0];
	endfunction

	pf2rgb_pkg::src_mode_t source_mode_q;
	pf2rgb_pkg::pix_job_t  job;
	logic                  job_valid;
	logic                  job_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mode_q <= pf2rgb_pkg::MODE_RGB565;
		end else if (cfg_valid && cfg_ready) begin
			source_mode_q <= pf2rgb_pkg::src_mode_t'(cfg_data);
		end
	end

	pf2rgb_unpack u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_zero  (byte_zero),
		.byte_one   (byte_one),
		.byte_two   (byte_two),
		.byte_three (byte_three),
		.mode       (source_mode_q),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job)
	);

	// stage enables, a stage moves when the one after it is empty or moving
	logic valid_s2, valid_s3, valid_s4, valid_s5;
	logic en2, en3, en4, en5;

	assign en5       = !valid_s5 || out_ready;
	assign en4       = !valid_s4 || en5;
	assign en3       = !valid_s3 || en4;
	assign en2       = !valid_s2 || en3;
	assign job_ready = en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en2) valid_s2 <= job_valid;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
		end
	end

	// stage 2: operand prep
	logic                    yuv_s2, video_s2, last_s2;
	logic [23:0]             rgb_s2;
	logic signed [8:0]       ys_s2, du_s2, dv_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			yuv_s2   <= job.yuv;
			video_s2 <= job.video;
			last_s2  <= job.last;
			rgb_s2   <= {job.blue, job.green, job.red};
			ys_s2    <= job.video ? $signed({1'b0, job.luma} - pf2rgb_pkg::LUMA_OFFSET)
				: $signed({1'b0, job.luma});
			du_s2    <= $signed({1'b0, job.cb} - pf2rgb_pkg::CHROMA_OFFSET);
			dv_s2    <= $signed({1'b0, job.cr} - pf2rgb_pkg::CHROMA_OFFSET);
		end
	end

	// stage 3: coefficient products
	logic                    yuv_s3, last_s3;
	logic [23:0]             rgb_s3;
	logic signed [ACC_W-1:0] py_s3, pr_s3, pgv_s3, pgu_s3, pb_s3;
	logic signed [ACC_W-1:0] ys_x, du_x, dv_x;

	assign ys_x = ACC_W'(ys_s2);
	assign du_x = ACC_W'(du_s2);
	assign dv_x = ACC_W'(dv_s2);

	always_ff @(posedge clk) begin
		if (en3) begin
			yuv_s3  <= yuv_s2;
			last_s3 <= last_s2;
			rgb_s3  <= rgb_s2;
			py_s3   <= video_s2 ? K_VR_Y * ys_x : ys_x <<< COEF_FRAC_BITS;
			pr_s3   <= (video_s2 ? K_VR_RV : K_FR_RV) * dv_x;
			pgv_s3  <= (video_s2 ? K_VR_GV : K_FR_GV) * dv_x;
			pgu_s3  <= (video_s2 ? K_VR_GU : K_FR_GU) * du_x;
			pb_s3   <= (video_s2 ? K_VR_BU : K_FR_BU) * du_x;
		end
	end

	// stage 4: sums
	logic                    yuv_s4, last_s4;
	logic [23:0]             rgb_s4;
	logic signed [ACC_W-1:0] r_s4, g_s4, b_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			yuv_s4  <= yuv_s3;
			last_s4 <= last_s3;
			rgb_s4  <= rgb_s3;
			r_s4    <= py_s3 + pr_s3;
			g_s4    <= py_s3 - pgv_s3 - pgu_s3;
			b_s4    <= py_s3 + pb_s3;
		end
	end

	// stage 5: shift, clamp and output register
	logic [7:0] blue_s5, green_s5, red_s5;
	logic       last_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			last_s5  <= last_s4;
			blue_s5  <= yuv_s4 ? shift_clamp(b_s4) : rgb_s4[23:16];
			green_s5 <= yuv_s4 ? shift_clamp(g_s4) : rgb_s4[15:8];
			red_s5   <= yuv_s4 ? shift_clamp(r_s4) : rgb_s4[7:0];
		end
	end

	assign out_valid  = valid_s5;
	assign blue_out   = blue_s5;
	assign green_out  = green_s5;
	assign red_out    = red_s5;
	assign last_pixel = last_s5;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !out_ready |=> valid_s5 && $stable(blue_s5) && $stable(last_s5))
		else $error("stalled output pixel changed");

	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && en5 |=> valid_s5)
		else $error("pixel dropped between sum and clamp stages");

	a_job_move: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> valid_s2)
		else $error("pixel beat dropped at pipeline entry");

endmodule

/* design/pf2rgb_unpack.sv */
// ----------------------------------------------------------------------------
// pf2rgb_unpack
// holds one source unit and splits it into one or two pixel beats
// ----------------------------------------------------------------------------
module pf2rgb_unpack (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             byte_zero,
	input  logic [7:0]             byte_one,
	input  logic [7:0]             byte_two,
	input  logic [7:0]             byte_three,
	input  pf2rgb_pkg::src_mode_t  mode,
	output logic                   job_valid,
	input  logic                   job_ready,
	output pf2rgb_pkg::pix_job_t   job
);

	logic                  valid_s1;
	logic                  phase_q;
	logic [7:0]            b0_s1, b1_s1, b2_s1, b3_s1;
	pf2rgb_pkg::src_mode_t mode_s1;
	logic                  two_beats;
	logic                  last_beat;
	logic                  in_take;

	always_comb begin
		job = '0;
		two_beats = 1'b0;
		unique case (mode_s1)
			pf2rgb_pkg::MODE_RGB565: begin
				job.blue  = {b0_s1[4:0], 3'b000};
				job.green = {b1_s1[2:0], b0_s1[7:5], 2'b00};
				job.red   = {b1_s1[7:3], 3'b000};
			end
			pf2rgb_pkg::MODE_BGR24, pf2rgb_pkg::MODE_BGR32: begin
				job.blue  = b0_s1;
				job.green = b1_s1;
				job.red   = b2_s1;
			end
			pf2rgb_pkg::MODE_RGB24, pf2rgb_pkg::MODE_RGB32: begin
				job.blue  = b2_s1;
				job.green = b1_s1;
				job.red   = b0_s1;
			end
			pf2rgb_pkg::MODE_UYVY: begin
				two_beats = 1'b1;
				job.luma  = phase_q ? b3_s1 : b1_s1;
				job.cb    = b0_s1;
				job.cr    = b2_s1;
			end
			pf2rgb_pkg::MODE_YUY2, pf2rgb_pkg::MODE_PLANAR: begin
				two_beats = 1'b1;
				job.video = (mode_s1 == pf2rgb_pkg::MODE_PLANAR);
				job.luma  = phase_q ? b2_s1 : b0_s1;
				job.cb    = b1_s1;
				job.cr    = b3_s1;
			end
			default: begin
				job.blue  = b0_s1;
			end
		endcase
		job.yuv  = two_beats;
		last_beat = !two_beats || phase_q;
		job.last = last_beat;
	end

	assign job_valid = valid_s1;
	assign in_ready  = !valid_s1 || (job_ready && last_beat);
	assign in_take   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
			phase_q  <= 1'b0;
		end else if (valid_s1 && job_ready) begin
			if (last_beat) begin
				valid_s1 <= 1'b0;
				phase_q  <= 1'b0;
			end else begin
				phase_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			b0_s1   <= byte_zero;
			b1_s1   <= byte_one;
			b2_s1   <= byte_two;
			b3_s1   <= byte_three;
			mode_s1 <= mode;
		end
	end

	a_second_beat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && two_beats && !phase_q && job_ready |=> valid_s1 && phase_q)
		else $error("second pixel beat of a luma-chroma unit lost");

	a_take_frees: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && valid_s1 |-> job_ready && last_beat)
		else $error("new unit taken while the held one still has beats");

	a_phase_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !phase_q)
		else $error("phase left set with no unit held");

endmodule

/* verif/tb_pixel_format_to_rgb24_unit.sv */
// ----------------------------------------------------------------------------
// tb_pixel_format_to_rgb24_unit
// self-checking bench for the pixel format to rgb24 unit
// ----------------------------------------------------------------------------
// Every source mode is set over the cfg channel between drained phases. A
// short directed set per mode hits byte extremes and chroma midpoints in most
// modes, then random units run under four idle patterns: none, sender gaps,
// receiver stalls and both. Each accepted unit is converted here into its
// one or two bmp pixels, and every output beat is compared against the
// oldest of those. One long receiver hold-off fills the pipe and stalls the
// input, and every mode change waits for all pixels to drain.
// ----------------------------------------------------------------------------
module tb_pixel_format_to_rgb24_unit;

	localparam int FRAC         = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASES       = 32;
	localparam int PHASE_UNITS  = 44;
	localparam int TAIL_CYCLES  = 12;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
	} src_unit_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last;
	} pixel_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_data = 3'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] byte_zero = 8'd0;
	logic [7:0] byte_one = 8'd0;
	logic [7:0] byte_two = 8'd0;
	logic [7:0] byte_three = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] blue_out;
	logic [7:0] green_out;
	logic [7:0] red_out;
	logic       last_pixel;
	logic       rx_hold = 1'b0;

	src_unit_t             unit_q[$];
	pixel_t                pending_pixels[$];
	pf2rgb_pkg::src_mode_t pix_mode = pf2rgb_pkg::MODE_RGB565;
	int                    queued_total = 0;
	int                    accepted_total = 0;
	int                    send_idle_pct = 0;
	int                    stall_pct = 0;
	int                    mismatch_cnt = 0;
	int                    cycle_cnt = 0;

	pixel_format_to_rgb24_unit #(.COEF_FRAC_BITS(FRAC)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_zero  (byte_zero),
		.byte_one   (byte_one),
		.byte_two   (byte_two),
		.byte_three (byte_three),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.blue_out   (blue_out),
		.green_out  (green_out),
		.red_out    (red_out),
		.last_pixel (last_pixel)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// truncated q-format coefficient from a value in millionths
	function automatic longint q_coef(input longint micro);
		return (micro << FRAC) / 64'sd1000000;
	endfunction

	function automatic logic [7:0] shift_clamp(input longint acc);
		longint r;
		r = acc >>> FRAC;
		if (r > 255)
			return 8'd255;
		if (r < 0)
			return 8'd0;
		return r[7:0];
	endfunction

	function automatic pixel_t yuv_pixel(input logic [7:0] y, input logic [7:0] u,
			input logic [7:0] v, input logic video, input logic last);
		pixel_t px;
		longint yy, du, dv;
		du = longint'(u) - 128;
		dv = longint'(v) - 128;
		if (video) begin
			yy = q_coef(1164000) * (longint'(y) - 16);
			px.red   = shift_clamp(yy + q_coef(1596000) * dv);
			px.green = shift_clamp(yy - q_coef(813000) * dv - q_coef(391000) * du);
			px.blue  = shift_clamp(yy + q_coef(2018000) * du);
		end else begin
			yy = longint'(y) << FRAC;
			px.red   = shift_clamp(yy + q_coef(1370705) * dv);
			px.green = shift_clamp(yy - q_coef(698001) * dv - q_coef(337633) * du);
			px.blue  = shift_clamp(yy + q_coef(1732446) * du);
		end
		px.last = last;
		return px;
	endfunction

	function automatic void convert_unit(input src_unit_t su);
		pixel_t px;
		px.last = 1'b1;
		case (pix_mode)
			pf2rgb_pkg::MODE_RGB565: begin
				px.blue  = {su.b0[4:0], 3'b000};
				px.green = {su.b1[2:0], su.b0[7:5], 2'b00};
				px.red   = {su.b1[7:3], 3'b000};
				pending_pixels.push_back(px);
			end
			pf2rgb_pkg::MODE_BGR24, pf2rgb_pkg::MODE_BGR32: begin
				px.blue  = su.b0;
				px.green = su.b1;
				px.red   = su.b2;
				pending_pixels.push_back(px);
			end
			pf2rgb_pkg::MODE_RGB24, pf2rgb_pkg::MODE_RGB32: begin
				px.blue  = su.b2;
				px.green = su.b1;
				px.red   = su.b0;
				pending_pixels.push_back(px);
			end
			pf2rgb_pkg::MODE_YUY2: begin
				pending_pixels.push_back(yuv_pixel(su.b0, su.b1, su.b3, 1'b0, 1'b0));
				pending_pixels.push_back(yuv_pixel(su.b2, su.b1, su.b3, 1'b0, 1'b1));
			end
			pf2rgb_pkg::MODE_UYVY: begin
				pending_pixels.push_back(yuv_pixel(su.b1, su.b0, su.b2, 1'b0, 1'b0));
				pending_pixels.push_back(yuv_pixel(su.b3, su.b0, su.b2, 1'b0, 1'b1));
			end
			default: begin
				pending_pixels.push_back(yuv_pixel(su.b0, su.b1, su.b3, 1'b1, 1'b0));
				pending_pixels.push_back(yuv_pixel(su.b2, su.b1, su.b3, 1'b1, 1'b1));
			end
		endcase
	endfunction

	function automatic void add_unit(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3);
		unit_q.push_back({b0, b1, b2, b3});
		queued_total++;
	endfunction

	// biased toward the extremes and the luma and chroma offsets
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'($urandom_range(24, 8));
			3: return 8'($urandom_range(136, 120));
			4: return 8'($urandom_range(255, 230));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic set_mode(input pf2rgb_pkg::src_mode_t m);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pix_mode = m;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (accepted_total != queued_total || pending_pixels.size() != 0);
	endtask

	// driver
	always @(posedge clk) begin
		src_unit_t su;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				convert_unit({byte_zero, byte_one, byte_two, byte_three});
				accepted_total++;
			end
			if (!in_valid || in_ready) begin
				if (unit_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					su = unit_q.pop_front();
					in_valid   <= 1'b1;
					byte_zero  <= su.b0;
					byte_one   <= su.b1;
					byte_two   <= su.b2;
					byte_three <= su.b3;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		pixel_t px;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					$error("unexpected pixel beat: blue %0d green %0d red %0d last %0d",
						blue_out, green_out, red_out, last_pixel);
					mismatch_cnt++;
				end else begin
					px = pending_pixels.pop_front();
					if (blue_out !== px.blue) begin
						$error("blue_out: expected %0d, got %0d", px.blue, blue_out);
						mismatch_cnt++;
					end
					if (green_out !== px.green) begin
						$error("green_out: expected %0d, got %0d", px.green, green_out);
						mismatch_cnt++;
					end
					if (red_out !== px.red) begin
						$error("red_out: expected %0d, got %0d", px.red, red_out);
						mismatch_cnt++;
					end
					if (last_pixel !== px.last) begin
						$error("last_pixel: expected %0d, got %0d", px.last, last_pixel);
						mismatch_cnt++;
					end
				end
			end
			out_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
		end
	end

	// long receiver hold-off while the sender keeps offering units
	initial begin
		do @(posedge clk); while (!(accepted_total > 300 && unit_q.size() > 20));
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int idle_sel;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_mode(pf2rgb_pkg::MODE_RGB565);
		add_unit(8'h00, 8'h00, 8'h00, 8'h00);
		add_unit(8'hff, 8'hff, 8'hff, 8'hff);
		add_unit(8'he0, 8'h07, 8'h5a, 8'ha5);
		add_unit(8'h1f, 8'hf8, 8'ha5, 8'h5a);
		drain();
		set_mode(pf2rgb_pkg::MODE_BGR24);
		add_unit(8'h01, 8'h02, 8'h03, 8'hff);
		drain();
		set_mode(pf2rgb_pkg::MODE_RGB24);
		add_unit(8'h10, 8'h20, 8'h30, 8'h40);
		drain();
		set_mode(pf2rgb_pkg::MODE_BGR32);
		add_unit(8'hff, 8'h00, 8'h80, 8'h7f);
		drain();
		set_mode(pf2rgb_pkg::MODE_RGB32);
		add_unit(8'hff, 8'hfe, 8'hfd, 8'hfc);
		add_unit(8'h00, 8'h01, 8'h02, 8'h03);
		drain();
		set_mode(pf2rgb_pkg::MODE_YUY2);
		add_unit(8'h00, 8'h00, 8'h00, 8'h00);
		add_unit(8'hff, 8'hff, 8'hff, 8'hff);
		add_unit(8'h00, 8'h80, 8'hff, 8'h80);
		add_unit(8'h80, 8'h00, 8'h80, 8'hff);
		drain();
		set_mode(pf2rgb_pkg::MODE_UYVY);
		add_unit(8'h00, 8'h00, 8'h00, 8'h00);
		add_unit(8'hff, 8'hff, 8'hff, 8'hff);
		add_unit(8'h80, 8'h00, 8'h80, 8'hff);
		drain();
		set_mode(pf2rgb_pkg::MODE_PLANAR);
		add_unit(8'h10, 8'h80, 8'heb, 8'h80);
		add_unit(8'h00, 8'h00, 8'hff, 8'hff);
		add_unit(8'hff, 8'hff, 8'h00, 8'h00);
		add_unit(8'h0f, 8'h80, 8'hff, 8'h80);
		drain();

		// each idle pattern meets every mode once
		for (int ph = 0; ph < PHASES; ph++) begin
			idle_sel = ph % 4;
			send_idle_pct = (idle_sel == 1) ? 74 : (idle_sel == 3) ? 20 : 0;
			stall_pct     = (idle_sel == 2) ? 74 : (idle_sel == 3) ? 20 : 0;
			set_mode(pf2rgb_pkg::src_mode_t'((ph / 4 + ph) % 8));
			for (int i = 0; i < PHASE_UNITS; i++)
				add_unit(rand_byte(), rand_byte(), rand_byte(), rand_byte());
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && pending_pixels.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
